// ===== rtl/core/qrs_pkg.sv =====
// shared widths, result codes and pipeline word types for the quadratic solver
`timescale 1ns / 1ps
package qrs_pkg;

  localparam int W        = 32;
  localparam int F        = 16;
  localparam int THR_W    = 16;
  localparam int RAD_W    = 2 * W + 2;
  localparam int ROOT_W   = W + 1;
  localparam int SREM_W   = W + 3;
  localparam int NB_W     = W + 1;
  localparam int DEN_W    = W + 2;
  localparam int NUM_W    = W + 3;
  localparam int NMAG_W   = W + 2;
  localparam int DMAG_W   = W + 1;
  localparam int QUO_W    = NMAG_W + F;
  localparam int SQ_CELLS = ROOT_W;
  localparam int DIV_CELLS = QUO_W;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_ONE    = 3'd1,
    KIND_TWO    = 3'd2,
    KIND_DOUBLE = 3'd3,
    KIND_INF    = 3'd4
  } kind_t;

  typedef struct packed {
    logic                     valid;
    kind_t                    kind;
    logic [RAD_W-1:0]         rad;
    logic [SREM_W-1:0]        rem;
    logic [ROOT_W-1:0]        root;
    logic signed [NB_W-1:0]   num_base;
    logic signed [DEN_W-1:0]  den;
  } sq_t;

  typedef struct packed {
    logic [QUO_W-1:0]  nq;
    logic [DMAG_W-1:0] rem;
    logic [DMAG_W-1:0] dmag;
    logic              neg;
  } div_lane_t;

  typedef struct packed {
    logic                  valid;
    kind_t                 kind;
    div_lane_t [1:0]       lane;
  } div_t;

endpackage

// ===== rtl/core/qrs_front.sv =====
// front stages: magnitudes, zero tests, products, discriminant and case decision
`timescale 1ns / 1ps
module qrs_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [qrs_pkg::W-1:0]     coef_a,
  input  logic [qrs_pkg::W-1:0]     coef_b,
  input  logic [qrs_pkg::W-1:0]     coef_c,
  input  logic [qrs_pkg::THR_W-1:0] thr,
  output qrs_pkg::sq_t              sq_o
);

  localparam int W = qrs_pkg::W;
  localparam int RAD_W = qrs_pkg::RAD_W;

  // stage 1: raw words
  logic         v1_r;
  logic [W-1:0] a1_r, b1_r, c1_r;

  // stage 2: magnitudes and zero flags
  logic         v2_r;
  logic [W-1:0] ma2_r, mb2_r, mc2_r;
  logic [W-1:0] a2_r, b2_r, c2_r;
  logic         na2_r, nb2_r, nc2_r, acneg2_r;

  // stage 3: products
  logic           v3_r;
  logic [2*W-1:0] bb3_r, ac3_r;
  logic [W-1:0]   a3_r, b3_r, c3_r;
  logic           na3_r, nb3_r, nc3_r, acneg3_r;

  // stage 4: discriminant magnitude and sign
  logic             v4_r;
  logic [RAD_W-1:0] dmag4_r;
  logic             dneg4_r;
  logic [W-1:0]     a4_r, b4_r, c4_r;
  logic             na4_r, nb4_r, nc4_r;

  logic [W-1:0]     ma, mb, mc, thr_x;
  logic [RAD_W-1:0] ac4, bbe, dsum, dmag;
  logic [RAD_W:0]   dfwd, drev;
  logic             dneg;
  logic [RAD_W-1:0] band;
  qrs_pkg::sq_t     sq_nxt;
  qrs_pkg::sq_t     sq_r;
  logic signed [qrs_pkg::NB_W-1:0] bx, cx;

  always_comb begin
    thr_x = {{(W - qrs_pkg::THR_W){1'b0}}, thr};
    ma = a1_r[W-1] ? (~a1_r + 1'b1) : a1_r;
    mb = b1_r[W-1] ? (~b1_r + 1'b1) : b1_r;
    mc = c1_r[W-1] ? (~c1_r + 1'b1) : c1_r;
  end

  always_comb begin
    ac4  = {ac3_r, 2'b00};
    bbe  = {2'b00, bb3_r};
    dsum = bbe + ac4;
    dfwd = {1'b0, bbe} - {1'b0, ac4};
    drev = {1'b0, ac4} - {1'b0, bbe};
    // borrow of b^2 - 4ac tells which side is larger
    dneg = !acneg3_r && dfwd[RAD_W];
    if (acneg3_r) begin
      dmag = dsum;
    end else if (dfwd[RAD_W]) begin
      dmag = drev[RAD_W-1:0];
    end else begin
      dmag = dfwd[RAD_W-1:0];
    end
  end

  always_comb begin
    band = {{(RAD_W - qrs_pkg::THR_W - qrs_pkg::F){1'b0}}, thr, {qrs_pkg::F{1'b0}}};
    bx = $signed({b4_r[W-1], b4_r});
    cx = $signed({c4_r[W-1], c4_r});
    sq_nxt = '0;
    sq_nxt.valid = v4_r;
    sq_nxt.rad = dmag4_r;
    if (na4_r) begin
      if (!nb4_r) begin
        sq_nxt.kind = qrs_pkg::KIND_ONE;
      end else if (nc4_r) begin
        sq_nxt.kind = qrs_pkg::KIND_INF;
      end else begin
        sq_nxt.kind = qrs_pkg::KIND_NONE;
      end
    end else if (dmag4_r <= band) begin
      sq_nxt.kind = qrs_pkg::KIND_DOUBLE;
    end else if (dneg4_r) begin
      sq_nxt.kind = qrs_pkg::KIND_NONE;
    end else begin
      sq_nxt.kind = qrs_pkg::KIND_TWO;
    end
    // linear case divides -c by b, quadratic cases divide by 2a
    if (na4_r) begin
      sq_nxt.num_base = -cx;
      sq_nxt.den = $signed({{2{b4_r[W-1]}}, b4_r});
    end else begin
      sq_nxt.num_base = -bx;
      sq_nxt.den = $signed({a4_r[W-1], a4_r, 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      sq_r.valid <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      sq_r <= sq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r <= coef_a;
      b1_r <= coef_b;
      c1_r <= coef_c;

      ma2_r <= ma;
      mb2_r <= mb;
      mc2_r <= mc;
      a2_r <= a1_r;
      b2_r <= b1_r;
      c2_r <= c1_r;
      na2_r <= (ma <= thr_x);
      nb2_r <= (mb <= thr_x);
      nc2_r <= (mc <= thr_x);
      acneg2_r <= a1_r[W-1] ^ c1_r[W-1];

      bb3_r <= mb2_r * mb2_r;
      ac3_r <= ma2_r * mc2_r;
      a3_r <= a2_r;
      b3_r <= b2_r;
      c3_r <= c2_r;
      na3_r <= na2_r;
      nb3_r <= nb2_r;
      nc3_r <= nc2_r;
      acneg3_r <= acneg2_r;

      dmag4_r <= dmag;
      dneg4_r <= dneg;
      a4_r <= a3_r;
      b4_r <= b3_r;
      c4_r <= c3_r;
      na4_r <= na3_r;
      nb4_r <= nb3_r;
      nc4_r <= nc3_r;
    end
  end

  assign sq_o = sq_r;

endmodule

// ===== rtl/core/qrs_sqrt_cell.sv =====
// one cell of the square root chain: settles one root bit per cycle while en is high
`timescale 1ns / 1ps
module qrs_sqrt_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  qrs_pkg::sq_t d_i,
  output qrs_pkg::sq_t q_o
);

  localparam int SREM_W = qrs_pkg::SREM_W;
  localparam int ROOT_W = qrs_pkg::ROOT_W;
  localparam int RAD_W  = qrs_pkg::RAD_W;

  logic [SREM_W+1:0] t, trial, diff;
  logic              ge;
  qrs_pkg::sq_t      q_nxt;
  qrs_pkg::sq_t      q_r;

  always_comb begin
    t = {d_i.rem, d_i.rad[RAD_W-1 -: 2]};
    trial = {{(SREM_W - ROOT_W){1'b0}}, d_i.root, 2'b01};
    ge = (t >= trial);
    diff = t - trial;
    q_nxt = d_i;
    q_nxt.rad = {d_i.rad[RAD_W-3:0], 2'b00};
    q_nxt.rem = ge ? diff[SREM_W-1:0] : t[SREM_W-1:0];
    q_nxt.root = {d_i.root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule

// ===== rtl/core/qrs_div_cell.sv =====
// one cell of the divider chain: one quotient bit per cycle on both lanes while en is high
`timescale 1ns / 1ps
module qrs_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  qrs_pkg::div_t d_i,
  output qrs_pkg::div_t q_o
);

  localparam int QUO_W  = qrs_pkg::QUO_W;
  localparam int DMAG_W = qrs_pkg::DMAG_W;

  qrs_pkg::div_t q_nxt;
  qrs_pkg::div_t q_r;

  always_comb begin
    logic [DMAG_W:0] t;
    logic [DMAG_W:0] diff;
    logic            ge;
    q_nxt = d_i;
    for (int i = 0; i < 2; i++) begin
      t = {d_i.lane[i].rem, d_i.lane[i].nq[QUO_W-1]};
      ge = (t >= {1'b0, d_i.lane[i].dmag});
      diff = t - {1'b0, d_i.lane[i].dmag};
      q_nxt.lane[i].rem = ge ? diff[DMAG_W-1:0] : t[DMAG_W-1:0];
      q_nxt.lane[i].nq = {d_i.lane[i].nq[QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule

// ===== rtl/core/quadratic_root_solver.sv =====
// top level: real roots of a*x^2 + b*x + c = 0 in signed Q16.16
//
// The input channel takes a word of three coefficients (in_coef_a, in_coef_b,
// in_coef_c) on in_valid/in_ready; the result channel returns one word per
// input on out_valid/out_ready: the solution kind, two roots and a clamp flag.
// cfg_wr_en/cfg_wr_data set the zero threshold; write it only while idle.
//
// From acceptance to out_valid a word passes five front stages (raw words,
// magnitudes, products, discriminant, case decision), 33 square root cells
// of one bit each, one numerator stage, 50 divider cells of one quotient bit
// each, and the output register. Throughput is one word per cycle while the
// output is not stalled; the square root and divider chains set the latency.
//
// Reset clears every stage's valid bit and sets the threshold to 1; no word
// is in flight afterwards. When the receiver stalls with a word waiting,
// the whole pipeline holds and in_ready drops until out_ready returns.
`timescale 1ns / 1ps
module quadratic_root_solver (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [31:0]          in_coef_a,
  input  logic signed [31:0]          in_coef_b,
  input  logic signed [31:0]          in_coef_c,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_root_kind,
  output logic signed [31:0]          out_first_root,
  output logic signed [31:0]          out_second_root,
  output logic                        out_saturated,
  input  logic                        cfg_wr_en,
  input  logic [15:0]                 cfg_wr_data
);

  localparam int W      = qrs_pkg::W;
  localparam int QUO_W  = qrs_pkg::QUO_W;
  localparam int NUM_W  = qrs_pkg::NUM_W;
  localparam int NMAG_W = qrs_pkg::NMAG_W;
  localparam int DMAG_W = qrs_pkg::DMAG_W;
  localparam int DEN_W  = qrs_pkg::DEN_W;
  localparam int ROOT_W = qrs_pkg::ROOT_W;
  localparam int NB_W   = qrs_pkg::NB_W;

  typedef struct packed {
    logic [W-1:0] root;
    logic         sat;
  } root_sat_t;

  logic [qrs_pkg::THR_W-1:0] thr_r;
  logic                      en;
  logic                      out_valid_r;
  qrs_pkg::kind_t            kind_r;
  logic [W-1:0]              first_r, second_r;
  logic                      sat_r;

  qrs_pkg::sq_t  sq_link  [0:qrs_pkg::SQ_CELLS];
  qrs_pkg::div_t div_link [0:qrs_pkg::DIV_CELLS];
  qrs_pkg::div_t prep_nxt;
  qrs_pkg::div_t prep_r;

  root_sat_t r0, r1;

  function automatic root_sat_t clamp_root(input qrs_pkg::div_lane_t ln);
    logic [QUO_W-1:0] lim;
    logic [QUO_W-1:0] val;
    root_sat_t        res;
    lim = ln.neg ? (QUO_W'(1) << (W - 1)) : ((QUO_W'(1) << (W - 1)) - 1'b1);
    res.sat = (ln.nq > lim);
    val = res.sat ? lim : ln.nq;
    res.root = ln.neg ? (~val[W-1:0] + 1'b1) : val[W-1:0];
    return res;
  endfunction

  // whole pipeline moves unless a finished word is stuck at the output
  assign en = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 16'd1;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  qrs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .coef_a   (in_coef_a),
    .coef_b   (in_coef_b),
    .coef_c   (in_coef_c),
    .thr      (thr_r),
    .sq_o     (sq_link[0])
  );

  for (genvar g = 0; g < qrs_pkg::SQ_CELLS; g++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_i   (sq_link[g]),
      .q_o   (sq_link[g+1])
    );
  end

  // numerators -b + s and -b - s (or the single linear/double numerator)
  always_comb begin
    qrs_pkg::sq_t            s;
    logic [ROOT_W-1:0]       sadd;
    logic signed [NUM_W-1:0] nbx, sx, n0, n1;
    logic [DMAG_W-1:0]       dm;
    logic [NMAG_W-1:0]       m0, m1;
    s = sq_link[qrs_pkg::SQ_CELLS];
    sadd = (s.kind == qrs_pkg::KIND_TWO) ? s.root : '0;
    nbx = $signed({{(NUM_W - NB_W){s.num_base[NB_W-1]}}, s.num_base});
    sx = $signed({{(NUM_W - ROOT_W){1'b0}}, sadd});
    n0 = nbx + sx;
    n1 = nbx - sx;
    m0 = n0[NUM_W-1] ? NMAG_W'(-n0) : NMAG_W'(n0);
    m1 = n1[NUM_W-1] ? NMAG_W'(-n1) : NMAG_W'(n1);
    dm = s.den[DEN_W-1] ? DMAG_W'(-s.den) : DMAG_W'(s.den);
    prep_nxt.valid = s.valid;
    prep_nxt.kind = s.kind;
    prep_nxt.lane[0].nq = {m0, {qrs_pkg::F{1'b0}}};
    prep_nxt.lane[1].nq = {m1, {qrs_pkg::F{1'b0}}};
    prep_nxt.lane[0].rem = '0;
    prep_nxt.lane[1].rem = '0;
    prep_nxt.lane[0].dmag = dm;
    prep_nxt.lane[1].dmag = dm;
    prep_nxt.lane[0].neg = n0[NUM_W-1] ^ s.den[DEN_W-1];
    prep_nxt.lane[1].neg = n1[NUM_W-1] ^ s.den[DEN_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_r.valid <= 1'b0;
    end else if (en) begin
      prep_r <= prep_nxt;
    end
  end

  assign div_link[0] = prep_r;

  for (genvar g = 0; g < qrs_pkg::DIV_CELLS; g++) begin : g_div
    qrs_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_i   (div_link[g]),
      .q_o   (div_link[g+1])
    );
  end

  assign r0 = clamp_root(div_link[qrs_pkg::DIV_CELLS].lane[0]);
  assign r1 = clamp_root(div_link[qrs_pkg::DIV_CELLS].lane[1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_link[qrs_pkg::DIV_CELLS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_r <= div_link[qrs_pkg::DIV_CELLS].kind;
      case (div_link[qrs_pkg::DIV_CELLS].kind)
        qrs_pkg::KIND_ONE: begin
          first_r <= r0.root;
          second_r <= '0;
          sat_r <= r0.sat;
        end
        qrs_pkg::KIND_DOUBLE: begin
          first_r <= r0.root;
          second_r <= r0.root;
          sat_r <= r0.sat;
        end
        qrs_pkg::KIND_TWO: begin
          first_r <= r0.root;
          second_r <= r1.root;
          sat_r <= r0.sat | r1.sat;
        end
        default: begin
          first_r <= '0;
          second_r <= '0;
          sat_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_root_kind = kind_r;
  assign out_first_root = first_r;
  assign out_second_root = second_r;
  assign out_saturated = sat_r;

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid right after reset");
  a_no_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_root_kind == qrs_pkg::KIND_NONE || out_root_kind == qrs_pkg::KIND_INF)
    |-> (out_first_root == 0 && out_second_root == 0 && !out_saturated))
    else $error("roots reported for a case without roots");
  a_double_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_kind == qrs_pkg::KIND_DOUBLE |-> out_first_root == out_second_root)
    else $error("double root with differing roots");
  a_single_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_kind == qrs_pkg::KIND_ONE |-> out_second_root == 0)
    else $error("linear case with a second root");
`endif

endmodule
